// ===== rtl/core/spfc_pkg.sv =====
// shared types and constants for the servo packet frame checker
// no dependencies

package spfc_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] CheckMask    = 8'hFE;
  localparam logic [ByteW-1:0] MinPacketLen = 8'd7;
  localparam logic [ByteW-1:0] CountMax     = 8'd255;

  // byte positions within a packet
  localparam logic [ByteW-1:0] PosSize   = 8'd2;
  localparam logic [ByteW-1:0] PosId     = 8'd3;
  localparam logic [ByteW-1:0] PosCmd    = 8'd4;
  localparam logic [ByteW-1:0] PosSumOne = 8'd5;
  localparam logic [ByteW-1:0] PosSumTwo = 8'd6;

  typedef enum logic [2:0] {
    FAIL_NONE  = 3'd0,
    FAIL_SHORT = 3'd1,
    FAIL_LEN   = 3'd2,
    FAIL_SUM1  = 3'd3,
    FAIL_SUM2  = 3'd4
  } fail_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             end_of_packet;
  } rx_item_t;

  typedef struct packed {
    logic             packet_ok;
    fail_e            fail_code;
    logic [ByteW-1:0] status_byte;
    logic [ByteW-1:0] detail_byte;
  } res_item_t;

  // control from the handshake logic to the frame state
  typedef struct packed {
    logic fire;  // the held byte is consumed this cycle
    logic last;  // it closes the packet
  } step_ctl_t;

endpackage

// ===== rtl/core/servo_packet_frame_checker_top.sv =====
// servo packet frame checker: one byte per cycle, one result per packet
// an accepted byte is held in the input register, then folded into the packet state;
//   the final byte's result is loaded into the result register as that byte is consumed
// throughput: one byte per cycle; only a held result at the output can stall the
//   final byte of a packet, plain bytes never wait on the output side
// reset: asynchronous, active low; empties both stages and clears all packet state
// depends on spfc_pkg, spfc_in_reg, spfc_frame_state, spfc_out_reg

module servo_packet_frame_checker_top import spfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rx_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_item_t out_item_o
);

  logic             held_valid;
  rx_item_t         held_item;
  logic             advance;
  logic             out_free;
  step_ctl_t        ctl;
  res_item_t        result;
  logic [ByteW-1:0] count;

  // input register: holds one byte until it can be folded into the packet state
  spfc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_item_o  (held_item)
  );

  // a plain byte always moves on; the final byte needs room in the result register
  assign advance  = held_valid && (!held_item.end_of_packet || out_free);
  assign ctl.fire = advance;
  assign ctl.last = held_item.end_of_packet;

  // running count, xor, header fields and the checks done on the final byte
  spfc_frame_state u_frame_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .byte_i   (held_item.rx_byte),
    .result_o (result),
    .count_o  (count)
  );

  // result register parts the output handshake from the byte stream
  spfc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ctl.fire && ctl.last),
    .result_i    (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .free_o      (out_free)
  );

  // a result only shows up right after the final byte of a packet was consumed
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctl.fire && ctl.last))
    else $error("result appeared without a final byte");

  // packet state starts over after the final byte
  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.fire && ctl.last) |=> (count == '0))
    else $error("byte count not cleared after packet end");

  // a held plain byte never stalls
  a_plain_byte_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_valid && !held_item.end_of_packet) |-> advance)
    else $error("plain byte stalled in input register");

  // ok flag agrees with the failure code
  a_ok_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.packet_ok == (out_item_o.fail_code == FAIL_NONE)))
    else $error("packet_ok disagrees with fail_code");

endmodule

// ===== rtl/core/spfc_in_reg.sv =====
// input register stage of the servo packet frame checker
// depends on spfc_pkg

module spfc_in_reg import spfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rx_item_t in_item_i,
  input  logic     advance_i,
  output logic     held_valid_o,
  output rx_item_t held_item_o
);

  logic     vld_q, vld_d;
  rx_item_t item_q;

  assign in_ready_o = !vld_q || advance_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign held_valid_o = vld_q;
  assign held_item_o  = item_q;

endmodule

// ===== rtl/core/spfc_frame_state.sv =====
// per-packet state (count, running xor, header fields) and the end-of-packet checks
// depends on spfc_pkg

module spfc_frame_state import spfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  step_ctl_t        ctl_i,
  input  logic [ByteW-1:0] byte_i,
  output res_item_t        result_o,
  output logic [ByteW-1:0] count_o
);

  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] size_q, size_d;
  logic [ByteW-1:0] sum1_q, sum1_d;
  logic [ByteW-1:0] sum2_q, sum2_d;
  logic [ByteW-1:0] prev_q, prev_d;

  // values after folding in the current byte
  logic [ByteW-1:0] xor_n, size_n, sum1_n, sum2_n;
  logic [ByteW-1:0] len;
  logic             in_sum;
  fail_e            code;

  assign in_sum = (count_q == PosSize) || (count_q == PosId) || (count_q == PosCmd) ||
                  (count_q >= MinPacketLen);
  assign xor_n  = in_sum ? (xor_q ^ byte_i) : xor_q;
  assign size_n = (count_q == PosSize)   ? byte_i : size_q;
  assign sum1_n = (count_q == PosSumOne) ? byte_i : sum1_q;
  assign sum2_n = (count_q == PosSumTwo) ? byte_i : sum2_q;
  assign len    = (count_q < CountMax) ? count_q + 8'd1 : CountMax;

  always_comb begin
    if (len < MinPacketLen) begin
      code = FAIL_SHORT;
    end else if (len != size_n) begin
      code = FAIL_LEN;
    end else if ((xor_n & CheckMask) != sum1_n) begin
      code = FAIL_SUM1;
    end else if ((~sum1_n & CheckMask) != sum2_n) begin
      code = FAIL_SUM2;
    end else begin
      code = FAIL_NONE;
    end
  end

  assign result_o.packet_ok   = (code == FAIL_NONE);
  assign result_o.fail_code   = code;
  assign result_o.status_byte = prev_q;
  assign result_o.detail_byte = byte_i;

  always_comb begin
    count_d = count_q;
    xor_d   = xor_q;
    size_d  = size_q;
    sum1_d  = sum1_q;
    sum2_d  = sum2_q;
    prev_d  = prev_q;
    if (ctl_i.fire) begin
      if (ctl_i.last) begin
        count_d = '0;
        xor_d   = '0;
        size_d  = '0;
        sum1_d  = '0;
        sum2_d  = '0;
        prev_d  = '0;
      end else begin
        count_d = (count_q < CountMax) ? count_q + 8'd1 : count_q;
        xor_d   = xor_n;
        size_d  = size_n;
        sum1_d  = sum1_n;
        sum2_d  = sum2_n;
        prev_d  = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      xor_q   <= '0;
      size_q  <= '0;
      sum1_q  <= '0;
      sum2_q  <= '0;
      prev_q  <= '0;
    end else begin
      count_q <= count_d;
      xor_q   <= xor_d;
      size_q  <= size_d;
      sum1_q  <= sum1_d;
      sum2_q  <= sum2_d;
      prev_q  <= prev_d;
    end
  end

  assign count_o = count_q;

endmodule

// ===== rtl/core/spfc_out_reg.sv =====
// result register of the servo packet frame checker
// depends on spfc_pkg

module spfc_out_reg import spfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_item_t result_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_item_t out_item_o,
  output logic      free_o
);

  logic      vld_q, vld_d;
  res_item_t item_q;

  // slot can take a new result when empty or being drained this cycle
  assign free_o = !vld_q || out_ready_i;
  assign vld_d  = load_i ? 1'b1 : (out_ready_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_item_o  = item_q;

endmodule
